@@ sv/scaled_icon_alpha_blit_unit_assert.svh @@
// Assertion macros for the icon blitter RTL.
`ifndef SCALED_ICON_ALPHA_BLIT_UNIT_ASSERT_SVH
`define SCALED_ICON_ALPHA_BLIT_UNIT_ASSERT_SVH

// Same-cycle implication, masked while reset is held.
`define SIAB_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held.
`define SIAB_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/siab_pkg.sv @@
// Shared widths, codes and reset values for the icon blitter.
`timescale 1ns / 1ps

package siab_pkg;

    localparam int ICON_PIXELS_DEF = 4096;

    // Beat field widths.
    localparam int LD_ADDR_W = 12;
    localparam int WORD_W    = 32;
    localparam int COORD_W   = 13;
    localparam int DIM_W     = 8;
    localparam int POS_W     = 12;
    localparam int COLOR_W   = 24;

    // Scaling datapath: product col*src_w, quotient below src_w, divisor dst_w.
    localparam int PROD_W     = 15;
    localparam int QUO_W      = 7;
    localparam int DEN_W      = 8;
    localparam int DIV_STAGES = (QUO_W + 1) / 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_W,
        CFG_SRC_H,
        CFG_DST_W,
        CFG_DST_H,
        CFG_BG,
        CFG_SCR_W,
        CFG_SCR_H
    } t_cfg_idx;

    localparam logic REQ_LOAD = 1'b0;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [12:0] SCREEN_LIMIT = 13'd4096;

    localparam logic [6:0]  RST_SRC_W = 7'd32;
    localparam logic [6:0]  RST_SRC_H = 7'd32;
    localparam logic [7:0]  RST_DST_W = 8'd32;
    localparam logic [7:0]  RST_DST_H = 8'd32;
    localparam logic [23:0] RST_BG    = 24'd0;
    localparam logic [12:0] RST_SCR_W = 13'd1024;
    localparam logic [12:0] RST_SCR_H = 13'd768;

endpackage

@@ sv/siab_req_if.sv @@
// Request channel: icon loads and per-pixel draw beats.
`timescale 1ns / 1ps

interface siab_req_if import siab_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [LD_ADDR_W-1:0]      load_addr;
    logic [WORD_W-1:0]         icon_word;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [DIM_W-1:0]          dst_col;
    logic [DIM_W-1:0]          dst_row;

    modport source (
        output valid, req_type, load_addr, icon_word, origin_x, origin_y, dst_col, dst_row,
        input  ready
    );
    modport sink (
        input  valid, req_type, load_addr, icon_word, origin_x, origin_y, dst_col, dst_row,
        output ready
    );
endinterface

@@ sv/siab_pix_if.sv @@
// Result channel: one pixel write beat per request.
`timescale 1ns / 1ps

interface siab_pix_if import siab_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   pixel_x;
    logic [POS_W-1:0]   pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               write_enable;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, write_enable,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, write_enable,
        output ready
    );
endinterface

@@ sv/siab_div_stage.sv @@
// One registered slice of the restoring divider used for texel scaling.
`timescale 1ns / 1ps

module siab_div_stage import siab_pkg::*; #(
    parameter int FIRST_BIT = QUO_W - 1,
    parameter int STEPS     = 2
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [PROD_W-1:0] i_rem,
    input  logic [QUO_W-1:0]  i_quo,
    input  logic [DEN_W-1:0]  i_den,
    output logic [PROD_W-1:0] o_rem,
    output logic [QUO_W-1:0]  o_quo
);

    logic [PROD_W-1:0] r_rem, n_rem;
    logic [QUO_W-1:0]  r_quo, n_quo;
    logic [PROD_W-1:0] trial;

    // Resolve quotient bits FIRST_BIT down to FIRST_BIT-STEPS+1.
    always_comb begin
        n_rem = i_rem;
        n_quo = i_quo;
        trial = '0;
        for (int s = 0; s < STEPS; s++) begin
            trial = PROD_W'(i_den) << (FIRST_BIT - s);
            if (n_rem >= trial) begin
                n_rem                = n_rem - trial;
                n_quo[FIRST_BIT - s] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

@@ sv/scaled_icon_alpha_blit_unit.sv @@
// Top level of the nearest-neighbor scaled ARGB icon blitter.
//
//  channel   | dir | handshake       | beat contents
//  ----------+-----+-----------------+------------------------------------------------
//  i_req     | in  | valid / ready   | req_type, load_addr, icon_word, origin, dst col/row
//  o_pix     | out | valid / ready   | pixel_x, pixel_y, pixel_color, write_enable
//  i_cfg_*   | in  | write enable    | register index and data, no read-back
//
// One beat enters per clock unless the output stalls; every beat yields exactly one
// result beat (stage 0 products, 4 divider slices of up to 2 quotient bits, index, store
// read, blend, output). The restoring divider maps dst_col/dst_row to source texels.
// Synchronous active-low reset clears the valid bits and presets the config registers;
// the icon store holds garbage until loaded and gets no clearing pass.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// collapse and a stalled output holds without losing or repeating a beat.
`timescale 1ns / 1ps

`include "scaled_icon_alpha_blit_unit_assert.svh"

module scaled_icon_alpha_blit_unit import siab_pkg::*; #(
    parameter int ICON_PIXELS = ICON_PIXELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    siab_req_if.sink              i_req,
    siab_pix_if.source            o_pix
);

    // Store index width; the wide index covers up to 32768 entries for compares.
    localparam int AW    = (ICON_PIXELS > 1) ? $clog2(ICON_PIXELS) : 1;
    localparam int IDX_W = 15;
    localparam logic [IDX_W-1:0] ICON_LIM = IDX_W'(ICON_PIXELS);

    // Stage map.
    localparam int S_IDX = DIV_STAGES + 1;
    localparam int S_MEM = S_IDX + 1;
    localparam int S_BLD = S_MEM + 1;
    localparam int S_OUT = S_BLD + 1;
    localparam int NS    = S_OUT + 1;

    typedef struct packed {
        logic               is_load;
        logic [IDX_W-1:0]   addr;     // load address, later the texel index
        logic [WORD_W-1:0]  word;
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic               ok;       // load in range, or draw still visible
    } t_pass;

    typedef struct packed {
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic             draw;
    } t_pos;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [6:0]         r_src_w, r_src_h;
    logic [7:0]         r_dst_w, r_dst_h;
    logic [COLOR_W-1:0] r_bg;
    logic [12:0]        r_scr_w, r_scr_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= RST_SRC_W;
            r_src_h <= RST_SRC_H;
            r_dst_w <= RST_DST_W;
            r_dst_h <= RST_DST_H;
            r_bg    <= RST_BG;
            r_scr_w <= RST_SCR_W;
            r_scr_h <= RST_SCR_H;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SRC_W: r_src_w <= i_cfg_data[6:0];
                CFG_SRC_H: r_src_h <= i_cfg_data[6:0];
                CFG_DST_W: r_dst_w <= i_cfg_data[7:0];
                CFG_DST_H: r_dst_h <= i_cfg_data[7:0];
                CFG_BG:    r_bg    <= i_cfg_data[COLOR_W-1:0];
                CFG_SCR_W: r_scr_w <= i_cfg_data[12:0];
                CFG_SCR_H: r_scr_h <= i_cfg_data[12:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    // Clip bounds never exceed the 12-bit screen space.
    logic [12:0] scr_w_lim, scr_h_lim;
    logic        size_ok;

    assign scr_w_lim = (r_scr_w > SCREEN_LIMIT) ? SCREEN_LIMIT : r_scr_w;
    assign scr_h_lim = (r_scr_h > SCREEN_LIMIT) ? SCREEN_LIMIT : r_scr_h;
    assign size_ok   = (r_src_w != '0) && (r_src_h != '0) && (r_dst_w != '0) && (r_dst_h != '0);

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when it drains
    // ------------------------------------------------------------------
    logic [NS-1:0] r_v;
    logic [NS-1:0] take;

    always_comb begin
        take[S_OUT] = !r_v[S_OUT] || o_pix.ready;
        for (int k = S_OUT - 1; k >= 0; k--) begin
            take[k] = !r_v[k] || take[k+1];
        end
    end

    assign i_req.ready = take[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (take[0]) begin
                r_v[0] <= i_req.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (take[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: screen position, clipping, scaling products
    // ------------------------------------------------------------------
    logic [13:0] px_full, py_full;
    logic        in_x, in_y, draw_ok, load_ok;
    t_pass       n_pass0;

    assign px_full = {i_req.origin_x[COORD_W-1], i_req.origin_x} + 14'(i_req.dst_col);
    assign py_full = {i_req.origin_y[COORD_W-1], i_req.origin_y} + 14'(i_req.dst_row);
    assign in_x    = !px_full[13] && (px_full[12:0] < scr_w_lim);
    assign in_y    = !py_full[13] && (py_full[12:0] < scr_h_lim);
    assign draw_ok = size_ok && (i_req.dst_col < r_dst_w) && (i_req.dst_row < r_dst_h)
                     && in_x && in_y;
    assign load_ok = IDX_W'(i_req.load_addr) < ICON_LIM;

    always_comb begin
        n_pass0.is_load = (i_req.req_type == REQ_LOAD);
        n_pass0.addr    = IDX_W'(i_req.load_addr);
        n_pass0.word    = i_req.icon_word;
        n_pass0.px      = px_full[POS_W-1:0];
        n_pass0.py      = py_full[POS_W-1:0];
        n_pass0.ok      = n_pass0.is_load ? load_ok : draw_ok;
    end

    t_pass             r_pass [S_MEM+1];
    logic [PROD_W-1:0] r_prod_x, r_prod_y;

    // ------------------------------------------------------------------
    // Stages 1..DIV_STAGES: sx = prod_x / dst_w, sy = prod_y / dst_h
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] div_rem_x [DIV_STAGES+1];
    logic [PROD_W-1:0] div_rem_y [DIV_STAGES+1];
    logic [QUO_W-1:0]  div_quo_x [DIV_STAGES+1];
    logic [QUO_W-1:0]  div_quo_y [DIV_STAGES+1];

    assign div_rem_x[0] = r_prod_x;
    assign div_rem_y[0] = r_prod_y;
    assign div_quo_x[0] = '0;
    assign div_quo_y[0] = '0;

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        localparam int FB = QUO_W - 1 - 2 * j;
        localparam int ST = (FB >= 1) ? 2 : 1;

        siab_div_stage #(.FIRST_BIT(FB), .STEPS(ST)) u_div_x (
            .i_clk (i_clk),
            .i_en  (take[j+1]),
            .i_rem (div_rem_x[j]),
            .i_quo (div_quo_x[j]),
            .i_den (r_dst_w),
            .o_rem (div_rem_x[j+1]),
            .o_quo (div_quo_x[j+1])
        );

        siab_div_stage #(.FIRST_BIT(FB), .STEPS(ST)) u_div_y (
            .i_clk (i_clk),
            .i_en  (take[j+1]),
            .i_rem (div_rem_y[j]),
            .i_quo (div_quo_y[j]),
            .i_den (r_dst_h),
            .o_rem (div_rem_y[j+1]),
            .o_quo (div_quo_y[j+1])
        );
    end

    // ------------------------------------------------------------------
    // Index stage: idx = sy * src_w + sx, range check against the store
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] texel_idx;
    t_pass            n_pass_idx;

    assign texel_idx = IDX_W'(div_quo_y[DIV_STAGES]) * IDX_W'(r_src_w)
                       + IDX_W'(div_quo_x[DIV_STAGES]);

    always_comb begin
        n_pass_idx = r_pass[DIV_STAGES];
        if (!r_pass[DIV_STAGES].is_load) begin
            n_pass_idx.addr = texel_idx;
            n_pass_idx.ok   = r_pass[DIV_STAGES].ok && (texel_idx < ICON_LIM);
        end
    end

    // Advance the side-band beat fields from stage 0 through the store stage.
    always_ff @(posedge i_clk) begin
        if (take[0]) begin
            r_pass[0] <= n_pass0;
            r_prod_x  <= PROD_W'(i_req.dst_col) * PROD_W'(r_src_w);
            r_prod_y  <= PROD_W'(i_req.dst_row) * PROD_W'(r_src_h);
        end
        for (int k = 1; k <= DIV_STAGES; k++) begin
            if (take[k]) begin
                r_pass[k] <= r_pass[k-1];
            end
        end
        if (take[S_IDX]) begin
            r_pass[S_IDX] <= n_pass_idx;
        end
        if (take[S_MEM]) begin
            r_pass[S_MEM] <= r_pass[S_IDX];
        end
    end

    // ------------------------------------------------------------------
    // Store stage: loads write here, draws read here, so order is kept
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] r_mem [ICON_PIXELS];
    logic [WORD_W-1:0] r_texel;
    logic [AW-1:0]     mem_addr;
    logic              mem_we;

    assign mem_addr = r_pass[S_IDX].addr[AW-1:0];
    assign mem_we   = take[S_MEM] && r_v[S_IDX] && r_pass[S_IDX].is_load && r_pass[S_IDX].ok;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= r_pass[S_IDX].word;
        end
        if (take[S_MEM]) begin
            r_texel <= r_mem[mem_addr];
        end
    end

    // ------------------------------------------------------------------
    // Blend stage: c*a + bg*(255-a) per channel
    // ------------------------------------------------------------------
    logic [7:0]         alpha;
    logic [15:0]        n_sum [3];
    logic [15:0]        r_sum [3];
    logic [COLOR_W-1:0] r_rgb;
    logic               r_opaque;
    t_pos               r_pos_bld;

    assign alpha = r_texel[WORD_W-1 -: 8];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            n_sum[ch] = 16'(r_texel[8*ch +: 8]) * 16'(alpha)
                        + 16'(r_bg[8*ch +: 8]) * 16'(ALPHA_OPAQUE - alpha);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take[S_BLD]) begin
            r_sum          <= n_sum;
            r_rgb          <= r_texel[COLOR_W-1:0];
            r_opaque       <= (alpha == ALPHA_OPAQUE);
            r_pos_bld.px   <= r_pass[S_MEM].px;
            r_pos_bld.py   <= r_pass[S_MEM].py;
            r_pos_bld.draw <= !r_pass[S_MEM].is_load && r_pass[S_MEM].ok && (alpha != '0);
        end
    end

    // ------------------------------------------------------------------
    // Output register: silent beats carry zero position and color
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0] blend_rgb;
    logic [POS_W-1:0]   r_out_px, r_out_py;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_we;

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            blend_rgb[8*ch +: 8] = r_sum[ch][15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (take[S_OUT]) begin
            r_out_we    <= r_pos_bld.draw;
            r_out_px    <= r_pos_bld.draw ? r_pos_bld.px : '0;
            r_out_py    <= r_pos_bld.draw ? r_pos_bld.py : '0;
            r_out_color <= !r_pos_bld.draw ? '0 : (r_opaque ? r_rgb : blend_rgb);
        end
    end

    assign o_pix.valid        = r_v[S_OUT];
    assign o_pix.pixel_x      = r_out_px;
    assign o_pix.pixel_y      = r_out_py;
    assign o_pix.pixel_color  = r_out_color;
    assign o_pix.write_enable = r_out_we;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SIAB_ASSERT_SAME(a_silent_beat_zero, i_clk, i_rst_n, o_pix.valid && !o_pix.write_enable, (o_pix.pixel_x == '0) && (o_pix.pixel_y == '0) && (o_pix.pixel_color == '0), "silent beat carries a nonzero payload")
    `SIAB_ASSERT_SAME(a_write_on_screen, i_clk, i_rst_n, o_pix.valid && o_pix.write_enable, (13'(o_pix.pixel_x) < scr_w_lim) && (13'(o_pix.pixel_y) < scr_h_lim), "pixel write outside the clip window")
    `SIAB_ASSERT_NEXT(a_blend_holds, i_clk, i_rst_n, r_v[S_BLD] && !take[S_OUT], r_v[S_BLD], "blend stage lost a beat under output stall")

endmodule

@@ bench/tb_scaled_icon_alpha_blit_unit.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the scaled icon alpha blitter: directed table, then random phases.

module tb_scaled_icon_alpha_blit_unit;
    import siab_pkg::*;

    localparam int     CLK_PERIOD    = 12;
    localparam int     RESET_CYCLES  = 9;
    // Pipeline is 9 deep; idle with margin to spare before touching registers.
    localparam int     SETTLE_CYCLES = 14;
    localparam int     IDLE_PCT      = 26;
    localparam int     NUM_PHASES    = 10;
    localparam longint TIMEOUT_NS    = 6_000_000;

    localparam int unsigned          STORE_DEPTH   = ICON_PIXELS_DEF;
    // Index 7 is past the register list; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
    localparam logic                 REQ_DRAW      = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic [LD_ADDR_W-1:0]      load_addr;
        logic [WORD_W-1:0]         icon_word;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [DIM_W-1:0]          dst_col;
        logic [DIM_W-1:0]          dst_row;
    } blit_req_t;

    typedef struct packed {
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [COLOR_W-1:0] color;
        logic               we;
    } pix_write_t;

    typedef struct packed {
        logic [6:0]  src_w;
        logic [6:0]  src_h;
        logic [7:0]  dst_w;
        logic [7:0]  dst_h;
        logic [23:0] bg;
        logic [12:0] scr_w;
        logic [12:0] scr_h;
    } blit_cfg_t;

    // One directed beat; when typed is set, want holds the result read off by hand.
    typedef struct packed {
        blit_req_t  req;
        logic       typed;
        pix_write_t want;
    } table_row_t;

    localparam pix_write_t NO_WRITE = '0;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    siab_req_if req_bus ();
    siab_pix_if pix_bus ();

    scaled_icon_alpha_blit_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_bus),
        .o_pix      (pix_bus)
    );

    // Shadow of the icon store and of the register file, as the block should hold them.
    logic [WORD_W-1:0] texel_mem    [STORE_DEPTH];
    bit                texel_loaded [STORE_DEPTH];
    blit_cfg_t         blit_cfg;

    pix_write_t pending_writes [$];
    table_row_t directed_rows  [$];

    // Set during one phase: no gaps from the sender and no stalls from the sink.
    bit steady;
    int n_mismatch;
    int n_results;
    int n_beats;
    int n_drawn;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Nearest-neighbor texel index; caller guarantees nonzero destination sizes.
    function automatic int unsigned texel_index(logic [DIM_W-1:0] col, logic [DIM_W-1:0] row);
        int unsigned sx;
        int unsigned sy;
        sx = int'(col) * int'(blit_cfg.src_w) / int'(blit_cfg.dst_w);
        sy = int'(row) * int'(blit_cfg.src_h) / int'(blit_cfg.dst_h);
        return sy * int'(blit_cfg.src_w) + sx;
    endfunction

    // Apply one accepted beat to the shadow store and return the pixel write it causes.
    function automatic pix_write_t predict_pixel_write(blit_req_t r);
        pix_write_t        res;
        int                px;
        int                py;
        int unsigned       scr_w_lim;
        int unsigned       scr_h_lim;
        int unsigned       idx;
        int unsigned       alpha;
        int unsigned       chan;
        int unsigned       bgc;
        logic [WORD_W-1:0] texel;
        res = NO_WRITE;
        if (r.req_type == REQ_LOAD) begin
            texel_mem[r.load_addr]    = r.icon_word;
            texel_loaded[r.load_addr] = 1'b1;
            return res;
        end
        if (blit_cfg.src_w == 0 || blit_cfg.src_h == 0 ||
            blit_cfg.dst_w == 0 || blit_cfg.dst_h == 0) begin
            return res;
        end
        if (r.dst_col >= blit_cfg.dst_w || r.dst_row >= blit_cfg.dst_h) begin
            return res;
        end
        px = int'($signed(r.origin_x)) + int'(r.dst_col);
        py = int'($signed(r.origin_y)) + int'(r.dst_row);
        // Screen bounds saturate at the 12-bit position range.
        scr_w_lim = (blit_cfg.scr_w < SCREEN_LIMIT) ? blit_cfg.scr_w : SCREEN_LIMIT;
        scr_h_lim = (blit_cfg.scr_h < SCREEN_LIMIT) ? blit_cfg.scr_h : SCREEN_LIMIT;
        if (px < 0 || py < 0 || px >= int'(scr_w_lim) || py >= int'(scr_h_lim)) begin
            return res;
        end
        idx = texel_index(r.dst_col, r.dst_row);
        if (idx >= STORE_DEPTH) begin
            return res;
        end
        texel = texel_mem[idx];
        alpha = texel[31:24];
        if (alpha == 0) begin
            return res;
        end
        res.color = texel[23:0];
        // Opaque texels pass straight through; anything else blends over the background.
        if (alpha != ALPHA_OPAQUE) begin
            for (int k = 0; k < 3; k++) begin
                chan = texel[8*k +: 8];
                bgc  = blit_cfg.bg[8*k +: 8];
                res.color[8*k +: 8] = 8'((chan * alpha + bgc * (int'(ALPHA_OPAQUE) - alpha)) >> 8);
            end
        end
        res.x  = px[POS_W-1:0];
        res.y  = py[POS_W-1:0];
        res.we = 1'b1;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------

    // Loads carry random draw fields and draws carry random load fields: the block ignores them.
    function automatic blit_req_t mk_load(logic [LD_ADDR_W-1:0] addr, logic [WORD_W-1:0] word);
        blit_req_t r;
        r.req_type  = REQ_LOAD;
        r.load_addr = addr;
        r.icon_word = word;
        r.origin_x  = COORD_W'($urandom);
        r.origin_y  = COORD_W'($urandom);
        r.dst_col   = DIM_W'($urandom);
        r.dst_row   = DIM_W'($urandom);
        return r;
    endfunction

    function automatic blit_req_t mk_draw(logic signed [COORD_W-1:0] ox,
                                          logic signed [COORD_W-1:0] oy,
                                          logic [DIM_W-1:0] col, logic [DIM_W-1:0] row);
        blit_req_t r;
        r.req_type  = REQ_DRAW;
        r.load_addr = LD_ADDR_W'($urandom);
        r.icon_word = $urandom;
        r.origin_x  = ox;
        r.origin_y  = oy;
        r.dst_col   = col;
        r.dst_row   = row;
        return r;
    endfunction

    // Bias alpha toward the transparent and opaque ends.
    function automatic logic [WORD_W-1:0] rand_texel();
        logic [7:0] alpha;
        case ($urandom_range(3))
            0: begin
                alpha = 8'h00;
            end
            1: begin
                alpha = ALPHA_OPAQUE;
            end
            default: begin
                alpha = 8'($urandom);
            end
        endcase
        return {alpha, 24'($urandom)};
    endfunction

    // Mostly inside the scaled size; sometimes anywhere in the field.
    function automatic logic [DIM_W-1:0] pick_dim(logic [DIM_W-1:0] lim);
        if (lim != 0 && $urandom_range(99) < 90) begin
            return DIM_W'($urandom_range(int'(lim) - 1));
        end
        return DIM_W'($urandom);
    endfunction

    // Aim the pixel on screen, at its edges or just past them; sometimes anywhere.
    function automatic logic signed [COORD_W-1:0] pick_origin(logic [DIM_W-1:0] offs,
                                                              int unsigned lim);
        int t;
        if (lim == 0 || $urandom_range(99) < 20) begin
            return COORD_W'($urandom);
        end
        case ($urandom_range(9))
            0: begin
                t = int'(lim);
            end
            1: begin
                t = int'(lim) - 1;
            end
            2: begin
                t = 0;
            end
            3: begin
                t = -1;
            end
            default: begin
                t = int'($urandom_range(lim - 1));
            end
        endcase
        return COORD_W'(t - int'(offs));
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Present one beat, hold it until accepted, then record what it should produce.
    task automatic send_req(blit_req_t r, logic typed = 1'b0, pix_write_t want = NO_WRITE);
        pix_write_t pred;
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                req_bus.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_bus.valid     <= 1'b1;
        req_bus.req_type  <= r.req_type;
        req_bus.load_addr <= r.load_addr;
        req_bus.icon_word <= r.icon_word;
        req_bus.origin_x  <= r.origin_x;
        req_bus.origin_y  <= r.origin_y;
        req_bus.dst_col   <= r.dst_col;
        req_bus.dst_row   <= r.dst_row;
        @(posedge i_clk);
        while (!req_bus.ready) begin
            @(posedge i_clk);
        end
        pred = predict_pixel_write(r);
        pending_writes.push_back(typed ? want : pred);
        n_beats++;
        if (pred.we) begin
            n_drawn++;
        end
    endtask

    // Drop valid and hold off until every result is back and the pipeline has emptied.
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        while (pending_writes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_config(blit_cfg_t c);
        write_reg(CFG_SRC_W, CFG_DATA_W'(c.src_w));
        write_reg(CFG_SRC_H, CFG_DATA_W'(c.src_h));
        write_reg(CFG_DST_W, CFG_DATA_W'(c.dst_w));
        write_reg(CFG_DST_H, CFG_DATA_W'(c.dst_h));
        write_reg(CFG_BG, c.bg);
        write_reg(CFG_SCR_W, CFG_DATA_W'(c.scr_w));
        write_reg(CFG_SCR_H, CFG_DATA_W'(c.scr_h));
        write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
        blit_cfg = c;
    endtask

    // Random loads and draws. A draw that would fetch a texel never loaded is
    // preceded by a load of that texel, since such a fetch is outside the contract.
    task automatic send_random_items(int count);
        blit_req_t        r;
        int unsigned      region;
        int unsigned      scr_w_lim;
        int unsigned      scr_h_lim;
        int unsigned      idx;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
        bit               sizes_ok;
        sizes_ok  = blit_cfg.src_w != 0 && blit_cfg.src_h != 0 &&
                    blit_cfg.dst_w != 0 && blit_cfg.dst_h != 0;
        region    = int'(blit_cfg.src_w) * int'(blit_cfg.src_h);
        if (region == 0 || region > STORE_DEPTH) begin
            region = STORE_DEPTH;
        end
        scr_w_lim = (blit_cfg.scr_w < SCREEN_LIMIT) ? blit_cfg.scr_w : SCREEN_LIMIT;
        scr_h_lim = (blit_cfg.scr_h < SCREEN_LIMIT) ? blit_cfg.scr_h : SCREEN_LIMIT;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 30) begin
                send_req(mk_load(($urandom_range(99) < 80) ?
                                 LD_ADDR_W'($urandom_range(region - 1)) : LD_ADDR_W'($urandom),
                                 rand_texel()));
            end else begin
                col = pick_dim(blit_cfg.dst_w);
                row = pick_dim(blit_cfg.dst_h);
                r   = mk_draw(pick_origin(col, scr_w_lim), pick_origin(row, scr_h_lim), col, row);
                if (sizes_ok && col < blit_cfg.dst_w && row < blit_cfg.dst_h) begin
                    idx = texel_index(col, row);
                    if (idx < STORE_DEPTH && !texel_loaded[idx]) begin
                        send_req(mk_load(LD_ADDR_W'(idx), rand_texel()));
                    end
                end
                send_req(r);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Random backpressure, none while the steady phase runs.
    initial begin : pixel_sink
        pix_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            pix_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        // Cap the log; the count still covers every failure.
        if (n_mismatch < 40) begin
            $display("MISMATCH result %0d %s: got 0x%0h want 0x%0h", n_results, what, got, want);
        end
        n_mismatch++;
    endtask

    // Compare each accepted result beat with the oldest pending prediction.
    always @(posedge i_clk) begin : result_check
        pix_write_t got;
        pix_write_t want;
        if (i_rst_n && pix_bus.valid && pix_bus.ready) begin
            got = {pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.pixel_color, pix_bus.write_enable};
            n_results++;
            if (pending_writes.size() == 0) begin
                report_mismatch("beat with nothing pending", 64'(got), 64'(0));
            end else begin
                want = pending_writes.pop_front();
                if (got.x !== want.x) begin
                    report_mismatch("pixel_x", 64'(got.x), 64'(want.x));
                end
                if (got.y !== want.y) begin
                    report_mismatch("pixel_y", 64'(got.y), 64'(want.y));
                end
                if (got.color !== want.color) begin
                    report_mismatch("pixel_color", 64'(got.color), 64'(want.color));
                end
                if (got.we !== want.we) begin
                    report_mismatch("write_enable", 64'(got.we), 64'(want.we));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin : stimulus
        blit_cfg_t phase_cfg   [NUM_PHASES];
        int        phase_items [NUM_PHASES];

        steady             = 1'b0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= '0;
        i_cfg_data        <= '0;
        req_bus.valid     <= 1'b0;
        req_bus.req_type  <= REQ_LOAD;
        req_bus.load_addr <= '0;
        req_bus.icon_word <= '0;
        req_bus.origin_x  <= '0;
        req_bus.origin_y  <= '0;
        req_bus.dst_col   <= '0;
        req_bus.dst_row   <= '0;
        blit_cfg = {RST_SRC_W, RST_SRC_H, RST_DST_W, RST_DST_H, RST_BG, RST_SCR_W, RST_SCR_H};

        // Directed rows run on the reset settings: 32x32 icon at 1:1, 1024x768 screen,
        // black background. Loads and clipped or transparent draws never write.
        directed_rows.push_back(table_row_t'{mk_load(12'd0, 32'hFF12_3456), 1'b1, NO_WRITE});
        directed_rows.push_back(table_row_t'{mk_load(12'd4095, 32'hFFFF_FFFF), 1'b1, NO_WRITE});
        directed_rows.push_back(table_row_t'{mk_load(12'd1, 32'h80FF_8040), 1'b1, NO_WRITE});
        directed_rows.push_back(table_row_t'{mk_load(12'd32, 32'h00AB_CDEF), 1'b1, NO_WRITE});
        directed_rows.push_back(table_row_t'{mk_load(12'd33, 32'h01FF_FFFF), 1'b1, NO_WRITE});
        directed_rows.push_back(table_row_t'{mk_load(12'd34, 32'hFE00_FF7F), 1'b1, NO_WRITE});
        directed_rows.push_back(table_row_t'{mk_load(12'd1023, 32'h7F00_FF00), 1'b1, NO_WRITE});
        directed_rows.push_back(table_row_t'{mk_load(12'd4095, 32'h0000_0000), 1'b1, NO_WRITE});
        // Opaque texel at the corner passes through unchanged.
        directed_rows.push_back(table_row_t'{mk_draw(0, 0, 0, 0), 1'b1,
                                             pix_write_t'{12'd0, 12'd0, 24'h123456, 1'b1}});
        // Half, near-zero and near-full alpha blends.
        directed_rows.push_back(table_row_t'{mk_draw(0, 0, 1, 0), 1'b0, NO_WRITE});
        directed_rows.push_back(table_row_t'{mk_draw(0, 0, 1, 1), 1'b0, NO_WRITE});
        directed_rows.push_back(table_row_t'{mk_draw(0, 0, 2, 1), 1'b0, NO_WRITE});
        directed_rows.push_back(table_row_t'{mk_draw(0, 0, 31, 31), 1'b0, NO_WRITE});
        // Transparent texel: no write.
        directed_rows.push_back(table_row_t'{mk_draw(0, 0, 0, 1), 1'b1, NO_WRITE});
        // Negative origin landing on column zero, and the last visible pixel.
        directed_rows.push_back(table_row_t'{mk_draw(-1, 0, 1, 0), 1'b0, NO_WRITE});
        directed_rows.push_back(table_row_t'{mk_draw(1022, 767, 1, 0), 1'b0, NO_WRITE});
        // One past the right and bottom edges, and both origin extremes.
        directed_rows.push_back(table_row_t'{mk_draw(1023, 0, 1, 0), 1'b1, NO_WRITE});
        directed_rows.push_back(table_row_t'{mk_draw(0, 768, 0, 0), 1'b1, NO_WRITE});
        directed_rows.push_back(table_row_t'{mk_draw(-4096, -4096, 0, 0), 1'b1, NO_WRITE});
        directed_rows.push_back(table_row_t'{mk_draw(4095, 4095, 0, 0), 1'b1, NO_WRITE});
        // Column or row at or past the scaled size.
        directed_rows.push_back(table_row_t'{mk_draw(0, 0, 32, 0), 1'b1, NO_WRITE});
        directed_rows.push_back(table_row_t'{mk_draw(0, 0, 0, 32), 1'b1, NO_WRITE});
        directed_rows.push_back(table_row_t'{mk_draw(0, 0, 255, 254), 1'b1, NO_WRITE});

        // Register settings per phase: reset values, smallest, 64x64 blown up to 255,
        // an icon too large for the store with screen bounds past 4096, zero sizes and
        // zero screen, an odd up/down scale, then random settings.
        phase_cfg[0] = blit_cfg;
        phase_cfg[1] = blit_cfg_t'{7'd1, 7'd1, 8'd1, 8'd1, 24'hFFFFFF, 13'd1, 13'd1};
        phase_cfg[2] = blit_cfg_t'{7'd64, 7'd64, 8'd255, 8'd255, 24'($urandom),
                                   13'd4096, 13'd4096};
        phase_cfg[3] = blit_cfg_t'{7'd127, 7'd127, 8'd255, 8'd255, 24'h000000,
                                   13'h1FFF, 13'h1FFF};
        phase_cfg[4] = blit_cfg_t'{7'd0, 7'd32, 8'd32, 8'd0, 24'($urandom), 13'd1024, 13'd768};
        phase_cfg[5] = blit_cfg_t'{7'd32, 7'd0, 8'd0, 8'd32, 24'($urandom), 13'd0, 13'd0};
        phase_cfg[6] = blit_cfg_t'{7'd7, 7'd13, 8'd200, 8'd9, 24'($urandom), 13'd640, 13'd480};
        for (int p = 7; p < NUM_PHASES; p++) begin
            phase_cfg[p] = blit_cfg_t'{7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                                       8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                                       24'($urandom),
                                       13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096))};
        end
        // Zero-size phases can only produce empty results; keep them short.
        foreach (phase_items[p]) begin
            phase_items[p] = (p == 4 || p == 5) ? 60 : 180;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        end

        // Between phases the sender stops until every result is back, then reprograms.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                drain_results();
                apply_config(phase_cfg[p]);
            end
            steady = (p == 2);
            send_random_items(phase_items[p]);
        end
        drain_results();

        $display("Covered %0d request beats over %0d register settings; %0d results, %0d drawn",
                 n_beats, NUM_PHASES, n_results, n_drawn);
        $display("Settings ranged from 1x1 to oversized icons, zero sizes and clipped screens");
        if (n_mismatch == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Hard stop if the handshakes hang.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
